[design/average_predictor_reconstruct_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the average predictor reconstruction block
// Concurrent checks clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef AVERAGE_PREDICTOR_RECONSTRUCT_ASSERT_SVH
`define AVERAGE_PREDICTOR_RECONSTRUCT_ASSERT_SVH

`ifndef SYNTH
`define APR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define APR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define APR_ASSERT_IMP(lbl, ante, cons)
`define APR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[design/apr_pkg.sv]
// ----------------------------------------------------------------------------
// apr_pkg
// Shared constants and types of the average predictor reconstruction block.
// ----------------------------------------------------------------------------
package apr_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int CFG_W      = 11;
    localparam int CFG_ADDR_W = 1;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 3;
    localparam int PIX_W      = CHAN_W * NUM_CHAN;

    localparam int CMP_COL_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int CMP_ROW_W = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd320;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd200;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             use_left;
        logic             use_up;
        logic             row_end;
        logic             frame_end;
    } t_pos;

endpackage

[design/apr_line_ram.sv]
// ----------------------------------------------------------------------------
// apr_line_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module apr_line_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/apr_position.sv]
// ----------------------------------------------------------------------------
// apr_position
// Frame size registers and the column and row counters of the pixel stream.
// ----------------------------------------------------------------------------
module apr_position (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [apr_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [apr_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                             i_advance,
    output apr_pkg::t_pos                    o_pos
);

    localparam int ColW    = apr_pkg::COL_W;
    localparam int RowW    = apr_pkg::ROW_W;
    localparam int CmpColW = apr_pkg::CMP_COL_W;
    localparam int CmpRowW = apr_pkg::CMP_ROW_W;

    logic [apr_pkg::CFG_W-1:0] r_width;
    logic [apr_pkg::CFG_W-1:0] r_height;
    logic [ColW-1:0]           r_col;
    logic [ColW-1:0]           n_col;
    logic [RowW-1:0]           r_row;
    logic [RowW-1:0]           n_row;
    logic [ColW:0]             w_col_inc;
    logic [RowW:0]             w_row_inc;
    logic                      w_row_end;
    logic                      w_last_row;

    assign w_col_inc  = {1'b0, r_col} + 1'b1;
    assign w_row_inc  = {1'b0, r_row} + 1'b1;
    assign w_row_end  = (CmpColW'(w_col_inc) >= CmpColW'(r_width)) ||
                        (r_col == ColW'(apr_pkg::MAX_WIDTH - 1));
    assign w_last_row = (CmpRowW'(w_row_inc) >= CmpRowW'(r_height)) ||
                        (r_row == RowW'(apr_pkg::MAX_HEIGHT - 1));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_advance) begin
            if (w_row_end) begin
                n_col = '0;
                n_row = w_last_row ? '0 : w_row_inc[RowW-1:0];
            end else begin
                n_col = w_col_inc[ColW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= apr_pkg::WIDTH_RESET;
            r_height <= apr_pkg::HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_we) begin
                case (apr_pkg::t_cfg_reg'(i_cfg_addr))
                    apr_pkg::CFG_WIDTH: begin
                        r_width <= i_cfg_wdata;
                    end
                    apr_pkg::CFG_HEIGHT: begin
                        r_height <= i_cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_pos.col       = r_col;
    assign o_pos.use_left  = (r_col != '0);
    assign o_pos.use_up    = (r_row != '0);
    assign o_pos.row_end   = w_row_end;
    assign o_pos.frame_end = w_row_end && w_last_row;

endmodule

[design/apr_recon.sv]
// ----------------------------------------------------------------------------
// apr_recon
// Average prediction and modulo-256 reconstruction of the three channels.
// ----------------------------------------------------------------------------
module apr_recon (
    input  apr_pkg::t_pix i_res,
    input  apr_pkg::t_pix i_left,
    input  apr_pkg::t_pix i_up,
    input  logic          i_use_left,
    input  logic          i_use_up,
    output apr_pkg::t_pix o_rec
);

    localparam int ChanW = apr_pkg::CHAN_W;

    for (genvar k = 0; k < apr_pkg::NUM_CHAN; k++) begin : g_chan
        logic [ChanW-1:0] w_left;
        logic [ChanW-1:0] w_up;
        logic [ChanW:0]   w_sum;

        assign w_left = i_use_left ? i_left[k*ChanW +: ChanW] : '0;
        assign w_up   = i_use_up   ? i_up[k*ChanW +: ChanW]   : '0;
        assign w_sum  = {1'b0, w_left} + {1'b0, w_up};
        assign o_rec[k*ChanW +: ChanW] = i_res[k*ChanW +: ChanW] + w_sum[ChanW:1];
    end

endmodule

[design/average_predictor_reconstruct.sv]
// ----------------------------------------------------------------------------
// average_predictor_reconstruct
// Average-filter reconstruction of a raster-order Y/Cb/Cr pixel stream.
// ----------------------------------------------------------------------------
// One pixel is accepted every clock cycle unless m_axis_tready stalls the
// output. It passes an input register and then an output register, which
// presents its result on m_axis_tdata. The line store read is issued at
// acceptance, and a same-cycle write to that entry is forwarded, so
// one-pixel-wide frames also run at full rate. The left neighbor is fed back
// from the pixel just finished, which keeps the path to two adds and one
// shift per channel. The line store needs no clearing after reset; column
// and row counters restart at zero.
module average_predictor_reconstruct (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [apr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [apr_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // res_y [7:0], res_cb [15:8], res_cr [23:16]
    input  logic [apr_pkg::PIX_W-1:0]      s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // rec_y [7:0], rec_cb [15:8], rec_cr [23:16]
    output logic [apr_pkg::PIX_W-1:0]      m_axis_tdata,
    // row_end [0]
    output logic [0:0]                     m_axis_tuser,
    output logic                           m_axis_tlast
);

`include "average_predictor_reconstruct_assert.svh"

    apr_pkg::t_pos w_pos;
    apr_pkg::t_pix w_rec;
    apr_pkg::t_pix w_up;
    apr_pkg::t_pix w_ram_rdata;
    logic          w_s_accept;
    logic          w_move;

    logic          r_in_valid;
    apr_pkg::t_pix r_res;
    apr_pkg::t_pos r_pos;
    logic          r_byp_valid;
    apr_pkg::t_pix r_byp_data;
    apr_pkg::t_pix r_left;

    logic          r_out_valid;
    apr_pkg::t_pix r_out_rec;
    logic          r_out_row_end;
    logic          r_out_frame_end;

    assign w_move        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_move;
    assign w_s_accept    = s_axis_tvalid && s_axis_tready;

    apr_position u_position (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_advance   (w_s_accept),
        .o_pos       (w_pos)
    );

    apr_line_ram #(
        .DATA_W (apr_pkg::PIX_W),
        .DEPTH  (apr_pkg::MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_move),
        .i_waddr (r_pos.col),
        .i_wdata (w_rec),
        .i_re    (w_s_accept),
        .i_raddr (w_pos.col),
        .o_rdata (w_ram_rdata)
    );

    assign w_up = r_byp_valid ? r_byp_data : w_ram_rdata;

    apr_recon u_recon (
        .i_res      (r_res),
        .i_left     (r_left),
        .i_up       (w_up),
        .i_use_left (r_pos.use_left),
        .i_use_up   (r_pos.use_up),
        .o_rec      (w_rec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_move) begin
                r_in_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_res       <= s_axis_tdata;
            r_pos       <= w_pos;
            r_byp_valid <= w_move && (r_pos.col == w_pos.col);
            r_byp_data  <= w_rec;
        end
        if (w_move) begin
            r_left          <= w_rec;
            r_out_rec       <= w_rec;
            r_out_row_end   <= r_pos.row_end;
            r_out_frame_end <= r_pos.frame_end;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_rec;
    assign m_axis_tuser[0] = r_out_row_end;
    assign m_axis_tlast    = r_out_frame_end;

    `APR_ASSERT_IMP(a_frame_end_ends_row, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0])
    `APR_ASSERT_NEXT(a_in_stage_holds, r_in_valid && !w_move, r_in_valid && $stable(r_pos))
    `APR_ASSERT_NEXT(a_row_wraps, w_s_accept && w_pos.row_end, w_pos.col == '0)

endmodule
